// File: hdl/byte_vector_simd_alu_defines.svh
// ----------------------------------------------------------------------------
// byte_vector_simd_alu_defines.svh
// Assertion macros shared by the byte vector ALU.
// ----------------------------------------------------------------------------
`ifndef BYTE_VECTOR_SIMD_ALU_DEFINES_SVH
`define BYTE_VECTOR_SIMD_ALU_DEFINES_SVH

// cond must hold at every clock edge outside reset
`define BVSA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// ante implies cons in the same cycle
`define BVSA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hdl/bvsa_pkg.sv
// ----------------------------------------------------------------------------
// bvsa_pkg
// Types, opcodes and helper functions for the byte vector ALU.
// ----------------------------------------------------------------------------
package bvsa_pkg;

    localparam int LANE_COUNT = 16;
    localparam int LANE_W     = 8;
    localparam int WORD_W     = 64;
    localparam int HALF_W     = 32;
    localparam int SCALAR_W   = 16;
    localparam int COUNT_W    = 5;

    localparam logic [LANE_W-1:0] ZERO_BYTE = 8'h00;
    localparam logic [LANE_W-1:0] ONES_BYTE = 8'hFF;

    typedef logic [LANE_W-1:0]                   t_byte;
    typedef logic [LANE_COUNT-1:0][LANE_W-1:0]   t_vec;

    typedef enum logic [3:0] {
        OP_EQ       = 4'd0,
        OP_OR       = 4'd1,
        OP_AND      = 4'd2,
        OP_ANDNOT   = 4'd3,
        OP_NOT      = 4'd4,
        OP_SHUFFLE  = 4'd5,
        OP_SHR      = 4'd6,
        OP_CLMUL    = 4'd7,
        OP_MOVEMASK = 4'd8,
        OP_COUNT    = 4'd9,
        OP_SPLAT    = 4'd10
    } t_op;

    // control that travels alongside the lane data into the merge stage
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_ctl;

    // four 32x32 carry-less partial products
    typedef struct packed {
        logic [WORD_W-1:0] p11;
        logic [WORD_W-1:0] p10;
        logic [WORD_W-1:0] p01;
        logic [WORD_W-1:0] p00;
    } t_clmul_pp;

    function automatic logic [WORD_W-1:0] clmul32(input logic [HALF_W-1:0] x,
                                                  input logic [HALF_W-1:0] y);
        logic [WORD_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < HALF_W; i++) begin
            if (y[i]) begin
                acc = acc ^ ({{HALF_W{1'b0}}, x} << i);
            end
        end
        return acc;
    endfunction

    function automatic logic [2:0] pop4(input logic [3:0] v);
        return {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]} + {2'b00, v[3]};
    endfunction

    function automatic logic [COUNT_W-1:0] pop16(input logic [LANE_COUNT-1:0] v);
        logic [3:0] s0;
        logic [3:0] s1;
        s0 = {1'b0, pop4(v[3:0])}  + {1'b0, pop4(v[7:4])};
        s1 = {1'b0, pop4(v[11:8])} + {1'b0, pop4(v[15:12])};
        return {1'b0, s0} + {1'b0, s1};
    endfunction

endpackage

// File: hdl/bvsa_lane.sv
// ----------------------------------------------------------------------------
// bvsa_lane
// One byte lane: computes the lane's byte for all bytewise operations.
// ----------------------------------------------------------------------------
module bvsa_lane (
    input  logic           i_clk,
    input  bvsa_pkg::t_op  i_op,
    input  bvsa_pkg::t_vec i_a_vec,
    input  bvsa_pkg::t_byte i_a_byte,
    input  bvsa_pkg::t_byte i_b_byte,
    input  bvsa_pkg::t_byte i_shift_amount,
    input  bvsa_pkg::t_byte i_splat_value,
    output bvsa_pkg::t_byte o_byte,
    output logic           o_sign
);
    import bvsa_pkg::*;

    t_byte r_byte;
    t_byte n_byte;
    logic  r_sign;

    always_comb begin
        case (i_op)
            OP_EQ:      n_byte = (i_a_byte == i_b_byte) ? ONES_BYTE : ZERO_BYTE;
            OP_OR:      n_byte = i_a_byte | i_b_byte;
            OP_AND:     n_byte = i_a_byte & i_b_byte;
            OP_ANDNOT:  n_byte = ~i_a_byte & i_b_byte;
            OP_NOT:     n_byte = ~i_a_byte;
            // index bit 7 zeroes the lane; bits 6:4 are ignored
            OP_SHUFFLE: n_byte = i_b_byte[7] ? ZERO_BYTE : i_a_vec[i_b_byte[3:0]];
            OP_SHR:     n_byte = (i_shift_amount[7:3] != 5'd0) ? ZERO_BYTE
                                 : (i_a_byte >> i_shift_amount[2:0]);
            OP_SPLAT:   n_byte = i_splat_value;
            default:    n_byte = ZERO_BYTE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_sign <= i_a_byte[LANE_W-1];
    end

    assign o_byte = r_byte;
    assign o_sign = r_sign;

endmodule

// File: hdl/bvsa_clmul.sv
// ----------------------------------------------------------------------------
// bvsa_clmul
// Carry-less multiply front end: four registered 32x32 partial products.
// ----------------------------------------------------------------------------
module bvsa_clmul (
    input  logic                  i_clk,
    input  logic [63:0]           i_a,
    input  logic [63:0]           i_b,
    output bvsa_pkg::t_clmul_pp   o_pp
);
    import bvsa_pkg::*;

    t_clmul_pp r_pp;

    always_ff @(posedge i_clk) begin
        r_pp.p00 <= clmul32(i_a[HALF_W-1:0],      i_b[HALF_W-1:0]);
        r_pp.p01 <= clmul32(i_a[HALF_W-1:0],      i_b[WORD_W-1:HALF_W]);
        r_pp.p10 <= clmul32(i_a[WORD_W-1:HALF_W], i_b[HALF_W-1:0]);
        r_pp.p11 <= clmul32(i_a[WORD_W-1:HALF_W], i_b[WORD_W-1:HALF_W]);
    end

    assign o_pp = r_pp;

endmodule

// File: hdl/bvsa_merge.sv
// ----------------------------------------------------------------------------
// bvsa_merge
// Merge stage: gathers lane bytes, sign bits and clmul partials into the
// registered result beat.
// ----------------------------------------------------------------------------
module bvsa_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bvsa_pkg::t_ctl      i_ctl,
    input  bvsa_pkg::t_vec      i_lane_vec,
    input  logic [15:0]         i_signs,
    input  bvsa_pkg::t_clmul_pp i_pp,
    output logic                o_valid,
    output logic [63:0]         o_result_lo,
    output logic [63:0]         o_result_hi,
    output logic [15:0]         o_scalar_result
);
    import bvsa_pkg::*;

    logic                  r_valid;
    logic [2*WORD_W-1:0]   r_vec;
    logic [2*WORD_W-1:0]   n_vec;
    logic [SCALAR_W-1:0]   r_scalar;
    logic [SCALAR_W-1:0]   n_scalar;
    logic [2*WORD_W-1:0]   w_clmul;

    assign w_clmul = {i_pp.p11, {WORD_W{1'b0}}}
                   ^ {{HALF_W{1'b0}}, i_pp.p01 ^ i_pp.p10, {HALF_W{1'b0}}}
                   ^ {{WORD_W{1'b0}}, i_pp.p00};

    always_comb begin
        n_vec    = '0;
        n_scalar = '0;
        if (i_ctl.valid) begin
            case (i_ctl.op)
                OP_EQ, OP_OR, OP_AND, OP_ANDNOT, OP_NOT,
                OP_SHUFFLE, OP_SHR, OP_SPLAT: n_vec = i_lane_vec;
                OP_CLMUL:    n_vec    = w_clmul;
                OP_MOVEMASK: n_scalar = i_signs;
                OP_COUNT:    n_scalar = {{(SCALAR_W-COUNT_W){1'b0}}, pop16(i_signs)};
                default: begin
                    n_vec    = '0;
                    n_scalar = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_vec    <= '0;
            r_scalar <= '0;
        end else begin
            r_valid  <= i_ctl.valid;
            r_vec    <= n_vec;
            r_scalar <= n_scalar;
        end
    end

    assign o_valid         = r_valid;
    assign o_result_lo     = r_vec[WORD_W-1:0];
    assign o_result_hi     = r_vec[2*WORD_W-1:WORD_W];
    assign o_scalar_result = r_scalar;

endmodule

// File: hdl/byte_vector_simd_alu.sv
// ----------------------------------------------------------------------------
// byte_vector_simd_alu
// 128-bit ALU over sixteen byte lanes with a two-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one command per clock: busy is high only while reset is held. Every
// accepted command gives exactly one result beat, marked by o_valid for one
// cycle, after the lane and merge registers. The first stage is sixteen byte
// lanes plus four 32x32 carry-less partial products; the second stage merges
// lane bytes, sign bits and partials into the result register. The receiver
// cannot stall, so results are never held and beats leave in command order.
`include "byte_vector_simd_alu_defines.svh"

module byte_vector_simd_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_req_type,
    input  logic [63:0] i_a_lo,
    input  logic [63:0] i_a_hi,
    input  logic [63:0] i_b_lo,
    input  logic [63:0] i_b_hi,
    input  logic [7:0]  i_shift_amount,
    input  logic [7:0]  i_splat_value,
    output logic        o_valid,
    output logic [63:0] o_result_lo,
    output logic [63:0] o_result_hi,
    output logic [15:0] o_scalar_result
);
    import bvsa_pkg::*;

    logic                  w_accept;
    t_op                   w_op;
    t_vec                  w_a_vec;
    t_vec                  w_b_vec;
    t_vec                  w_lane_vec;
    logic [LANE_COUNT-1:0] w_signs;
    t_clmul_pp             w_pp;
    t_ctl                  r_ctl;

    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;
    assign w_op     = t_op'(i_req_type);
    assign w_a_vec  = {i_a_hi, i_a_lo};
    assign w_b_vec  = {i_b_hi, i_b_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
            r_ctl.op    <= OP_EQ;
        end else begin
            r_ctl.valid <= w_accept;
            r_ctl.op    <= w_op;
        end
    end

    for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
        bvsa_lane u_lane (
            .i_clk          (i_clk),
            .i_op           (w_op),
            .i_a_vec        (w_a_vec),
            .i_a_byte       (w_a_vec[g]),
            .i_b_byte       (w_b_vec[g]),
            .i_shift_amount (i_shift_amount),
            .i_splat_value  (i_splat_value),
            .o_byte         (w_lane_vec[g]),
            .o_sign         (w_signs[g])
        );
    end

    bvsa_clmul u_clmul (
        .i_clk (i_clk),
        .i_a   (i_a_lo),
        .i_b   (i_b_lo),
        .o_pp  (w_pp)
    );

    bvsa_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (r_ctl),
        .i_lane_vec      (w_lane_vec),
        .i_signs         (w_signs),
        .i_pp            (w_pp),
        .o_valid         (o_valid),
        .o_result_lo     (o_result_lo),
        .o_result_hi     (o_result_hi),
        .o_scalar_result (o_scalar_result)
    );

    // one result beat per accepted command, after the lane and merge registers
    `BVSA_ASSERT_ALWAYS(a_latency, i_clk, i_rst_n, o_valid == $past(w_accept, 2), "result beat does not match accepted command")
    // scalar and vector results never both nonzero
    `BVSA_ASSERT_IMPL(a_scalar_excl, i_clk, i_rst_n, o_valid && (o_scalar_result != 16'd0), (o_result_lo == 64'd0) && (o_result_hi == 64'd0), "scalar result with nonzero vector")
    // idle cycles carry zero payload
    `BVSA_ASSERT_IMPL(a_idle_zero, i_clk, i_rst_n, !o_valid, (o_scalar_result == 16'd0) && (o_result_lo == 64'd0) && (o_result_hi == 64'd0), "payload nonzero without strobe")

endmodule
